FILE: rtl/core/txsn_pkg.sv
// Package for the transmit sequence number allocator.
// Holds field widths, operation and status codes, and the stage structs.
// No dependencies.
`default_nettype none

package txsn_pkg;

  localparam int SEQ_W             = 12;
  localparam int ADDR_W            = 48;
  localparam int TID_W             = 4;
  localparam int NUM_TIDS          = 16;
  localparam int OP_W              = 2;
  localparam int STATUS_W          = 2;
  localparam int MAX_RECEIVERS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_PEEK  = 2'd1,
    OP_QUERY = 2'd2,
    OP_SET   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_TABLE_FULL  = 2'd1,
    ST_UNKNOWN_RX  = 2'd2
  } status_t;

  typedef logic [NUM_TIDS-1:0][SEQ_W-1:0] seq_row_t;

  typedef struct packed {
    logic hit;
    logic full;
  } cam_rsp_t;

  typedef struct packed {
    op_t              op;
    logic             shared;
    logic             hit;
    logic             new_entry;
    status_t          status;
    logic [TID_W-1:0] tid;
    logic [SEQ_W-1:0] new_seq;
  } stage_ctl_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    status_t          status;
    logic             row_we;
    logic             shared_we;
    logic [SEQ_W-1:0] shared_nxt;
  } upd_t;

endpackage

`default_nettype wire

FILE: rtl/core/txsn_req_if.sv
// Request channel: valid/ready handshake with the request payload.
// Depends on txsn_pkg for field widths.
`default_nettype none

interface txsn_req_if;
  logic                          valid;
  logic                          ready;
  logic [txsn_pkg::OP_W-1:0]     op;
  logic                          is_qos_data;
  logic                          is_broadcast;
  logic [txsn_pkg::ADDR_W-1:0]   receiver_address;
  logic [txsn_pkg::TID_W-1:0]    tid;
  logic [txsn_pkg::SEQ_W-1:0]    new_sequence;

  modport source (
    output valid, op, is_qos_data, is_broadcast, receiver_address, tid, new_sequence,
    input  ready
  );

  modport sink (
    input  valid, op, is_qos_data, is_broadcast, receiver_address, tid, new_sequence,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/txsn_rsp_if.sv
// Result channel: valid/ready handshake with sequence number and status.
// Depends on txsn_pkg for field widths.
`default_nettype none

interface txsn_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [txsn_pkg::SEQ_W-1:0]    sequence_res;
  logic [txsn_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, sequence_res, status,
    input  ready
  );

  modport sink (
    input  valid, sequence_res, status,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/txsn_cam.sv
// Receiver address table: valid bits and addresses, parallel match,
// lowest free entry search and entry allocation. Depends on txsn_pkg.
`default_nettype none

module txsn_cam #(
  parameter  int MAX_RECEIVERS = txsn_pkg::MAX_RECEIVERS_DEF,
  localparam int IDX_W         = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [txsn_pkg::ADDR_W-1:0] lookup_addr,
  input  wire logic                        alloc_en,
  output      txsn_pkg::cam_rsp_t          rsp,
  output      logic [IDX_W-1:0]            hit_idx,
  output      logic [IDX_W-1:0]            free_idx
);
  import txsn_pkg::*;

  logic [MAX_RECEIVERS-1:0] valid_r;
  logic [ADDR_W-1:0]        addr_r [MAX_RECEIVERS];
  logic [MAX_RECEIVERS-1:0] match;

  always_comb begin
    for (int e = 0; e < MAX_RECEIVERS; e++) begin
      match[e] = valid_r[e] && (addr_r[e] == lookup_addr);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int e = 0; e < MAX_RECEIVERS; e++) begin
      if (match[e]) begin
        hit_idx = hit_idx | IDX_W'(e);
      end
    end
  end

  always_comb begin
    free_idx = '0;
    for (int e = MAX_RECEIVERS - 1; e >= 0; e--) begin
      if (!valid_r[e]) begin
        free_idx = IDX_W'(e);
      end
    end
  end

  assign rsp.hit  = |match;
  assign rsp.full = &valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (alloc_en) begin
      valid_r[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_en) begin
      addr_r[free_idx] <= lookup_addr;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/txsn_row_ram.sv
// Counter memory: one row of sixteen TID counters per receiver entry,
// one write and one registered read port. Depends on txsn_pkg.
`default_nettype none

module txsn_row_ram #(
  parameter  int MAX_RECEIVERS = txsn_pkg::MAX_RECEIVERS_DEF,
  localparam int IDX_W         = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire logic [IDX_W-1:0]   rd_idx,
  output      txsn_pkg::seq_row_t rd_row,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_idx,
  input  wire txsn_pkg::seq_row_t wr_row
);
  import txsn_pkg::*;

  seq_row_t mem [MAX_RECEIVERS];
  seq_row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_row;
    end
  end

  assign rd_row = rd_row_r;

endmodule

`default_nettype wire

FILE: rtl/core/txsn_seq_update.sv
// Counter update: picks the shared or per-receiver counter, forms the
// returned value and the write-back row. Depends on txsn_pkg.
`default_nettype none

module txsn_seq_update (
  input  wire txsn_pkg::stage_ctl_t        ctl,
  input  wire txsn_pkg::seq_row_t          row,
  input  wire logic [txsn_pkg::SEQ_W-1:0]  shared_cnt,
  output      txsn_pkg::upd_t              upd,
  output      txsn_pkg::seq_row_t          wr_row
);
  import txsn_pkg::*;

  logic [SEQ_W-1:0] lane;

  assign lane = row[ctl.tid];

  always_comb begin
    upd            = '0;
    upd.status     = ctl.status;
    upd.shared_nxt = shared_cnt;
    wr_row         = row;
    if (ctl.status == ST_OK) begin
      if (ctl.shared) begin
        case (ctl.op)
          OP_ALLOC: begin
            upd.seq        = shared_cnt;
            upd.shared_we  = 1'b1;
            upd.shared_nxt = shared_cnt + SEQ_W'(1);
          end
          OP_PEEK: begin
            upd.seq = shared_cnt;
          end
          OP_SET: begin
            upd.shared_we  = 1'b1;
            upd.shared_nxt = ctl.new_seq;
          end
          default: begin
            upd.seq = '0;
          end
        endcase
      end else if (ctl.new_entry) begin
        wr_row          = '0;
        wr_row[ctl.tid] = SEQ_W'(1);
        upd.row_we      = 1'b1;
      end else if (ctl.hit) begin
        case (ctl.op)
          OP_ALLOC: begin
            upd.seq         = lane;
            wr_row[ctl.tid] = lane + SEQ_W'(1);
            upd.row_we      = 1'b1;
          end
          OP_SET: begin
            wr_row[ctl.tid] = ctl.new_seq;
            upd.row_we      = 1'b1;
          end
          default: begin
            upd.seq = lane;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tx_sequence_number_allocator.sv
// Top level of the transmit sequence number allocator.
// Uses txsn_pkg, txsn_req_if, txsn_rsp_if, txsn_cam, txsn_row_ram, txsn_seq_update.
//
//   channel   modport  handshake     payload
//   in_chan   sink     valid/ready   op, is_qos_data, is_broadcast, receiver_address,
//                                    tid, new_sequence
//   out_chan  source   valid/ready   sequence_res, status
//
// One request per cycle unless out_chan stalls; results leave in request order.
// The rate is set by the counter row memory: one registered read and one
// write per cycle, with the write-back of the previous request forwarded.
// Reset clears the receiver valid bits and the shared counter at once.
// A stall on out_chan holds all three stages; in_chan stays ready while
// the input stage is empty.
`default_nettype none

module tx_sequence_number_allocator #(
  parameter int MAX_RECEIVERS = txsn_pkg::MAX_RECEIVERS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  txsn_req_if.sink   in_chan,
  txsn_rsp_if.source out_chan
);
  import txsn_pkg::*;

  localparam int IDX_W = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1;

  logic             adv;

  logic             a_valid_r;
  logic [OP_W-1:0]  a_op_r;
  logic             a_qos_r;
  logic             a_bcast_r;
  logic [ADDR_W-1:0] a_addr_r;
  logic [TID_W-1:0] a_tid_r;
  logic [SEQ_W-1:0] a_new_seq_r;

  cam_rsp_t         cam_rsp;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  op_t              a_op;
  logic             a_per_pair;
  logic             a_new_entry;
  stage_ctl_t       a_ctl;
  logic [IDX_W-1:0] a_idx;
  logic             rd_en;
  logic             alloc_en;

  logic             b_valid_r;
  stage_ctl_t       b_ctl_r;
  logic [IDX_W-1:0] b_idx_r;
  logic             byp_hit_r;
  seq_row_t         byp_row_r;
  seq_row_t         rd_row;
  seq_row_t         b_row;
  seq_row_t         wr_row;
  upd_t             upd;
  logic             wr_en;

  logic [SEQ_W-1:0] shared_r;
  logic             out_valid_r;
  logic [SEQ_W-1:0] out_seq_r;
  status_t          out_status_r;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !a_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      a_valid_r <= 1'b1;
    end else if (adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      a_op_r      <= in_chan.op;
      a_qos_r     <= in_chan.is_qos_data;
      a_bcast_r   <= in_chan.is_broadcast;
      a_addr_r    <= in_chan.receiver_address;
      a_tid_r     <= in_chan.tid;
      a_new_seq_r <= in_chan.new_sequence;
    end
  end

  txsn_cam #(
    .MAX_RECEIVERS(MAX_RECEIVERS)
  ) u_cam (
    .clk        (clk),
    .rst_n      (rst_n),
    .lookup_addr(a_addr_r),
    .alloc_en   (alloc_en),
    .rsp        (cam_rsp),
    .hit_idx    (hit_idx),
    .free_idx   (free_idx)
  );

  assign a_op        = op_t'(a_op_r);
  assign a_per_pair  = a_qos_r && !a_bcast_r;
  assign a_new_entry = (a_op == OP_ALLOC) && a_per_pair && !cam_rsp.hit && !cam_rsp.full;
  assign a_idx       = a_new_entry ? free_idx : hit_idx;
  assign rd_en       = adv && a_valid_r;
  assign alloc_en    = rd_en && a_new_entry;

  always_comb begin
    a_ctl           = '0;
    a_ctl.op        = a_op;
    a_ctl.shared    = (a_op != OP_QUERY) && !a_per_pair;
    a_ctl.hit       = cam_rsp.hit;
    a_ctl.new_entry = a_new_entry;
    a_ctl.tid       = a_tid_r;
    a_ctl.new_seq   = a_new_seq_r;
    a_ctl.status    = ST_OK;
    if (a_per_pair && !cam_rsp.hit) begin
      if ((a_op == OP_ALLOC) && cam_rsp.full) begin
        a_ctl.status = ST_TABLE_FULL;
      end else if (a_op == OP_SET) begin
        a_ctl.status = ST_UNKNOWN_RX;
      end
    end
  end

  txsn_row_ram #(
    .MAX_RECEIVERS(MAX_RECEIVERS)
  ) u_row_ram (
    .clk   (clk),
    .rd_en (rd_en),
    .rd_idx(a_idx),
    .rd_row(rd_row),
    .wr_en (wr_en),
    .wr_idx(b_idx_r),
    .wr_row(wr_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      b_ctl_r   <= a_ctl;
      b_idx_r   <= a_idx;
      byp_hit_r <= wr_en && (b_idx_r == a_idx);
      byp_row_r <= wr_row;
    end
  end

  assign b_row = byp_hit_r ? byp_row_r : rd_row;

  txsn_seq_update u_seq_update (
    .ctl       (b_ctl_r),
    .row       (b_row),
    .shared_cnt(shared_r),
    .upd       (upd),
    .wr_row    (wr_row)
  );

  assign wr_en = adv && b_valid_r && upd.row_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shared_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_valid_r;
      if (b_valid_r && upd.shared_we) begin
        shared_r <= upd.shared_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_seq_r    <= upd.seq;
      out_status_r <= upd.status;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sequence_res = out_seq_r;
  assign out_chan.status       = out_status_r;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Testbench for tx_sequence_number_allocator: directed and random requests with
// a scoreboard that tracks the receiver table and all counters itself.
// Depends on txsn_pkg, txsn_req_if, txsn_rsp_if and the allocator RTL.
`default_nettype none

module testbench;
  import txsn_pkg::*;

  localparam int MAX_RX      = MAX_RECEIVERS_DEF;
  localparam int NUM_ITEMS   = 2000;
  localparam int POOL_SIZE   = 20;
  localparam int DRAIN_ITEMS = 200;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    op_t               op;
    bit                qos;
    bit                bcast;
    bit [ADDR_W-1:0]   addr;
    bit [TID_W-1:0]    tid;
    bit [SEQ_W-1:0]    nseq;
  } seq_req_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    status_t          status;
  } seq_rsp_t;

  class txsn_seq_tracker;
    bit              rx_used [MAX_RX];
    bit [ADDR_W-1:0] rx_addr [MAX_RX];
    bit [SEQ_W-1:0]  tid_seq [MAX_RX][NUM_TIDS];
    bit [SEQ_W-1:0]  shared_seq;
    seq_rsp_t        pending[$];
    int              mismatches;

    function int find_rx(bit [ADDR_W-1:0] a);
      for (int e = 0; e < MAX_RX; e++) begin
        if (rx_used[e] && rx_addr[e] == a) return e;
      end
      return -1;
    endfunction

    function int find_free();
      for (int e = 0; e < MAX_RX; e++) begin
        if (!rx_used[e]) return e;
      end
      return -1;
    endfunction

    function void note_request(seq_req_t r);
      int       e;
      int       f;
      seq_rsp_t x;
      x.seq    = '0;
      x.status = ST_OK;
      e = find_rx(r.addr);
      if (r.op == OP_QUERY) begin
        if (e >= 0) x.seq = tid_seq[e][r.tid];
      end else if (!(r.qos && !r.bcast)) begin
        case (r.op)
          OP_ALLOC: begin
            x.seq      = shared_seq;
            shared_seq = shared_seq + SEQ_W'(1);
          end
          OP_PEEK: x.seq = shared_seq;
          default: shared_seq = r.nseq;
        endcase
      end else begin
        case (r.op)
          OP_ALLOC: begin
            if (e >= 0) begin
              x.seq            = tid_seq[e][r.tid];
              tid_seq[e][r.tid] = tid_seq[e][r.tid] + SEQ_W'(1);
            end else begin
              f = find_free();
              if (f < 0) begin
                x.status = ST_TABLE_FULL;
              end else begin
                rx_used[f] = 1'b1;
                rx_addr[f] = r.addr;
                for (int t = 0; t < NUM_TIDS; t++) tid_seq[f][t] = '0;
                tid_seq[f][r.tid] = SEQ_W'(1);
              end
            end
          end
          OP_PEEK: begin
            if (e >= 0) x.seq = tid_seq[e][r.tid];
          end
          default: begin
            if (e >= 0) tid_seq[e][r.tid] = r.nseq;
            else x.status = ST_UNKNOWN_RX;
          end
        endcase
      end
      pending.push_back(x);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [SEQ_W-1:0] seq, logic [STATUS_W-1:0] st);
      seq_rsp_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result seq=%0d status=%0d", seq, st));
        return;
      end
      want = pending.pop_front();
      if (seq !== want.seq)
        report($sformatf("sequence_res %0d, expected %0d", seq, want.seq));
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   requests_sent;
  bit   draining;

  txsn_req_if req_chan();
  txsn_rsp_if rsp_chan();

  txsn_seq_tracker tracker = new();
  seq_req_t        stim[$];
  bit [ADDR_W-1:0] rx_pool[POOL_SIZE];

  tx_sequence_number_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan.sink),
    .out_chan (rsp_chan.source)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit [ADDR_W-1:0] rand_addr();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic void add_req(op_t op, bit qos, bit bcast, bit [ADDR_W-1:0] addr,
                                  bit [TID_W-1:0] tid, bit [SEQ_W-1:0] nseq);
    seq_req_t r;
    r.op    = op;
    r.qos   = qos;
    r.bcast = bcast;
    r.addr  = addr;
    r.tid   = tid;
    r.nseq  = nseq;
    stim.push_back(r);
  endfunction

  function automatic seq_req_t make_random_req();
    seq_req_t r;
    int       kind;
    int       w;
    int       v;
    kind   = $urandom_range(0, 99);
    r.tid  = 4'($urandom_range(0, 15));
    r.nseq = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(4093, 4095))
                                         : 12'($urandom());
    r.addr = rx_pool[$urandom_range(0, POOL_SIZE - 1)];
    r.op   = op_t'($urandom_range(0, 3));
    if (kind < 60) begin
      r.qos   = 1'b1;
      r.bcast = 1'b0;
      w = $urandom_range(0, 9);
      if (w < 5) r.op = OP_ALLOC;
      else if (w == 5) r.op = OP_PEEK;
      else if (w == 6) r.op = OP_QUERY;
      else r.op = OP_SET;
    end else if (kind < 85) begin
      v = $urandom_range(0, 2);
      r.qos   = (v == 2);
      r.bcast = (v != 0);
      if ($urandom_range(0, 1) == 0) r.addr = rand_addr();
    end else begin
      r.qos   = 1'($urandom());
      r.bcast = 1'($urandom());
      r.addr  = rand_addr();
    end
    return r;
  endfunction

  task automatic send_req(seq_req_t r);
    req_chan.valid            <= 1'b1;
    req_chan.op               <= r.op;
    req_chan.is_qos_data      <= r.qos;
    req_chan.is_broadcast     <= r.bcast;
    req_chan.receiver_address <= r.addr;
    req_chan.tid              <= r.tid;
    req_chan.new_sequence     <= r.nseq;
    do @(posedge clk); while (req_chan.ready !== 1'b1);
    @(negedge clk);
    requests_sent++;
  endtask

  always @(posedge clk) begin
    seq_req_t r;
    if (rst_n) begin
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready)
        tracker.check_result(rsp_chan.sequence_res, rsp_chan.status);
      if (req_chan.valid && req_chan.ready === 1'b1) begin
        r.op    = op_t'(req_chan.op);
        r.qos   = req_chan.is_qos_data;
        r.bcast = req_chan.is_broadcast;
        r.addr  = req_chan.receiver_address;
        r.tid   = req_chan.tid;
        r.nseq  = req_chan.new_sequence;
        tracker.note_request(r);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (req_chan.valid && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) break;
    end
    $display("FAIL tx_sequence_number_allocator");
    $finish;
  end

  initial begin
    int stall_left;
    int cyc;
    bit hold_done;
    rsp_chan.ready = 1'b0;
    stall_left     = 0;
    cyc            = 0;
    hold_done      = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      cyc++;
      if (!hold_done && requests_sent >= 600) begin
        hold_done  = 1'b1;
        stall_left = $urandom_range(60, 90);
      end
      if (stall_left > 0) begin
        rsp_chan.ready <= 1'b0;
        stall_left--;
      end else if (!draining && cyc[7:6] != 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        rsp_chan.ready <= 1'b0;
      end else begin
        rsp_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    bit [ADDR_W-1:0] ones;
    int              n_directed;
    rst_n                     = 1'b0;
    requests_sent             = 0;
    draining                  = 1'b0;
    req_chan.valid            = 1'b0;
    req_chan.op               = '0;
    req_chan.is_qos_data      = 1'b0;
    req_chan.is_broadcast     = 1'b0;
    req_chan.receiver_address = '0;
    req_chan.tid              = '0;
    req_chan.new_sequence     = '0;

    ones       = '1;
    rx_pool[0] = '0;
    rx_pool[1] = ones;
    for (int i = 2; i < POOL_SIZE; i++) rx_pool[i] = rand_addr();

    // shared counter: non-QoS, broadcast QoS, peek, set and wrap
    add_req(OP_ALLOC, 1'b0, 1'b0, rand_addr(), 4'd0, 12'd0);
    add_req(OP_ALLOC, 1'b1, 1'b1, ones, 4'd15, 12'd0);
    add_req(OP_PEEK,  1'b0, 1'b1, '0, 4'd0, 12'd0);
    add_req(OP_SET,   1'b0, 1'b0, '0, 4'd0, 12'hFFF);
    add_req(OP_ALLOC, 1'b0, 1'b0, '0, 4'd0, 12'd0);
    add_req(OP_ALLOC, 1'b0, 1'b1, ones, 4'd7, 12'd0);
    // unknown receiver: peek, query, set
    add_req(OP_PEEK,  1'b1, 1'b0, ones, 4'd15, 12'd0);
    add_req(OP_QUERY, 1'b0, 1'b0, ones, 4'd15, 12'd0);
    add_req(OP_SET,   1'b1, 1'b0, ones, 4'd15, 12'hFFF);
    // new entries, per-TID wrap, query ignoring frame type
    add_req(OP_ALLOC, 1'b1, 1'b0, '0, 4'd0, 12'd0);
    add_req(OP_ALLOC, 1'b1, 1'b0, '0, 4'd0, 12'd0);
    add_req(OP_SET,   1'b1, 1'b0, '0, 4'd3, 12'd0);
    add_req(OP_ALLOC, 1'b1, 1'b0, ones, 4'd15, 12'd0);
    add_req(OP_SET,   1'b1, 1'b0, ones, 4'd15, 12'hFFF);
    add_req(OP_ALLOC, 1'b1, 1'b0, ones, 4'd15, 12'd0);
    add_req(OP_ALLOC, 1'b1, 1'b0, ones, 4'd15, 12'd0);
    add_req(OP_QUERY, 1'b0, 1'b1, ones, 4'd15, 12'd0);
    // fill the table, then overflow it
    for (int i = 2; i < MAX_RX; i++)
      add_req(OP_ALLOC, 1'b1, 1'b0, rx_pool[i], 4'($urandom_range(0, 15)), 12'd0);
    add_req(OP_ALLOC, 1'b1, 1'b0, rx_pool[MAX_RX], 4'd9, 12'd0);
    n_directed = stim.size();
    for (int i = n_directed; i < NUM_ITEMS; i++) stim.push_back(make_random_req());

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < stim.size(); i++) begin
      if (i >= stim.size() - DRAIN_ITEMS) draining = 1'b1;
      if (!draining && (i / 128) % 3 != 0 && $urandom_range(0, 4) == 0) begin
        req_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      send_req(stim[i]);
    end
    req_chan.valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("PASS tx_sequence_number_allocator");
    else
      $display("FAIL tx_sequence_number_allocator");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/txsn_pkg.sv
rtl/core/txsn_req_if.sv
rtl/core/txsn_rsp_if.sv
rtl/core/txsn_cam.sv
rtl/core/txsn_row_ram.sv
rtl/core/txsn_seq_update.sv
rtl/core/tx_sequence_number_allocator.sv
sim/testbench.sv
